// File: rtl/assert_macros.svh
// Assertion macros used by the stillness detector engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/wsd_pkg.sv
// Package with shared types and constants for the stillness detector.
package wsd_pkg;
  localparam int MaxSamplesDefault = 64;
  localparam int CoordBits         = 16;
  localparam int CountBits         = 7;

  localparam logic [1:0] RegWindow   = 2'd0;
  localparam logic [1:0] RegRadius   = 2'd1;
  localparam logic [1:0] RegFraction = 2'd2;

  typedef struct packed {
    logic                        pos_valid;
    logic [31:0]                 timestamp_ms;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic                 is_stationary;
    logic [CountBits-1:0] sample_count;
    logic [CountBits-1:0] inlier_count;
  } out_item_t;
endpackage

// File: rtl/wsd_queue.sv
// Two-entry queue between the front end and the evaluation engine.
module wsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_stall,
  input  wsd_pkg::in_item_t wr_data,
  output logic              rd_valid,
  input  logic              rd_take,
  output wsd_pkg::in_item_t rd_data
);
  import wsd_pkg::*;
  in_item_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slot[rd_ptr];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/wsd_engine.sv
// Sample ring, window trimming, centroid and inlier evaluation.
`include "assert_macros.svh"
module wsd_engine #(
  parameter int MAX_SAMPLES = wsd_pkg::MaxSamplesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_take,
  input  wsd_pkg::in_item_t  item,
  input  logic [15:0]        window_ms,
  input  logic [14:0]        inlier_radius,
  input  logic [8:0]         inlier_fraction_q8,
  output logic               res_valid,
  input  logic               res_stall,
  output wsd_pkg::out_item_t res
);
  import wsd_pkg::*;
  localparam int IdxBits = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CntBits = $clog2(MAX_SAMPLES + 1);
  localparam int SumBits = CoordBits + CntBits + 1;
  localparam int ErrBits = SumBits + CntBits + 1;
  localparam int LimBits = 15 + CntBits;
  localparam logic [CntBits-1:0] MaxCnt = CntBits'(MAX_SAMPLES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TRIM  = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_JUDGE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [31:0]                 mem_t [MAX_SAMPLES];
  logic signed [CoordBits-1:0] mem_x [MAX_SAMPLES];
  logic signed [CoordBits-1:0] mem_y [MAX_SAMPLES];
  logic [IdxBits-1:0] oldest;
  logic [CntBits-1:0] held;
  logic [31:0]        run_start;
  logic [31:0]        now;
  logic [CntBits-1:0] k;
  logic [CntBits-1:0] inliers;
  logic signed [SumBits-1:0] sx;
  logic signed [SumBits-1:0] sy;
  logic [LimBits-1:0] lim;
  logic [2*LimBits-1:0] lim2;
  logic [31:0]        rd_t;
  logic signed [CoordBits-1:0] rd_x;
  logic signed [CoordBits-1:0] rd_y;
  logic               rd_ok;
  logic               err_ok;
  logic [IdxBits-1:0] rd_addr;
  logic [IdxBits-1:0] wr_addr;
  logic [CntBits-1:0] held_next;
  logic [IdxBits-1:0] oldest_next;
  logic signed [ErrBits-1:0] ex;
  logic signed [ErrBits-1:0] ey;
  logic [ErrBits-1:0] ax;
  logic [ErrBits-1:0] ay;
  logic [ErrBits-1:0] ax_q;
  logic [ErrBits-1:0] ay_q;
  logic [2*ErrBits-1:0] sq_x;
  logic [2*ErrBits-1:0] sq_y;
  logic [2*ErrBits:0] err_sq;
  logic [CntBits+8:0] lhs;
  logic [CntBits+8:0] rhs;
  logic               eval_on;

  function automatic logic [IdxBits-1:0] ring(input logic [IdxBits-1:0] base,
                                              input logic [CntBits-1:0] off);
    logic [CntBits:0] s;
    begin
      s = {{(CntBits + 1 - IdxBits){1'b0}}, base} + {1'b0, off};
      if (s >= (CntBits + 1)'(MAX_SAMPLES)) s = s - (CntBits + 1)'(MAX_SAMPLES);
      ring = s[IdxBits-1:0];
    end
  endfunction

  assign item_take = (state == S_IDLE) && !res_valid;

  // Append position; ring full drops the oldest first.
  always_comb begin
    oldest_next = oldest;
    held_next   = held;
    if (held >= MaxCnt) begin
      oldest_next = ring(oldest, CntBits'(1));
      held_next   = MaxCnt - CntBits'(1);
    end
    wr_addr = ring(oldest_next, held_next);
  end

  always_comb begin
    unique case (state)
      S_TRIM:  rd_addr = oldest;
      default: rd_addr = ring(oldest, k);
    endcase
  end

  // Error terms n*v - S, taken as magnitudes and registered before squaring.
  assign ex = ErrBits'(signed'({1'b0, held})) * ErrBits'(rd_x) - ErrBits'(sx);
  assign ey = ErrBits'(signed'({1'b0, held})) * ErrBits'(rd_y) - ErrBits'(sy);
  assign ax = ex[ErrBits-1] ? ErrBits'(-ex) : ErrBits'(ex);
  assign ay = ey[ErrBits-1] ? ErrBits'(-ey) : ErrBits'(ey);
  assign sq_x = ax_q * ax_q;
  assign sq_y = ay_q * ay_q;
  assign err_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign lhs = (CntBits+9)'({inliers, 8'd0});
  assign rhs = (CntBits+9)'(inlier_fraction_q8 * held);

  always_ff @(posedge clk) begin
    rd_t <= mem_t[rd_addr];
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    if (item_valid && item_take && item.pos_valid) begin
      mem_t[wr_addr] <= item.timestamp_ms;
      mem_x[wr_addr] <= item.pos_x;
      mem_y[wr_addr] <= item.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      held      <= '0;
      run_start <= '0;
      res_valid <= 1'b0;
      rd_ok     <= 1'b0;
      err_ok    <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid && item_take) begin
            now <= item.timestamp_ms;
            if (!item.pos_valid) begin
              held <= '0;
              oldest <= '0;
              res <= '0;
              res_valid <= 1'b1;
            end else begin
              if (held == '0) run_start <= item.timestamp_ms;
              oldest <= oldest_next;
              held <= held_next + CntBits'(1);
              rd_ok <= 1'b0;
              state <= S_TRIM;
            end
          end
        end
        S_TRIM: begin
          // The oldest time is first fetched into rd_t, then compared.
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (held != '0 && (now - rd_t) > {16'd0, window_ms}) begin
              oldest <= ring(oldest, CntBits'(1));
              held <= held - CntBits'(1);
            end else begin
              k <= '0;
              sx <= '0;
              sy <= '0;
              inliers <= '0;
              eval_on <= (held != '0) && ((now - run_start) >= {16'd0, window_ms});
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (!eval_on) begin
            state <= S_JUDGE;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            sx <= sx + SumBits'(rd_x);
            sy <= sy + SumBits'(rd_y);
            if (k == held - CntBits'(1)) begin
              k <= '0;
              state <= S_PREP;
            end else begin
              k <= k + CntBits'(1);
            end
          end
        end
        S_PREP: begin
          lim  <= {{(LimBits-CntBits){1'b0}}, held} * {{CntBits{1'b0}}, inlier_radius};
          state <= S_EVAL;
        end
        S_EVAL: begin
          // Per sample, in order: fetch, error magnitudes, squared compare.
          if (!rd_ok && !err_ok) begin
            lim2 <= {{LimBits{1'b0}}, lim} * {{LimBits{1'b0}}, lim};
            rd_ok <= 1'b1;
          end else if (rd_ok) begin
            rd_ok <= 1'b0;
            ax_q <= ax;
            ay_q <= ay;
            err_ok <= 1'b1;
          end else begin
            err_ok <= 1'b0;
            if (err_sq <= {{(2*ErrBits+1-2*LimBits){1'b0}}, lim2}) begin
              inliers <= inliers + CntBits'(1);
            end
            if (k == held - CntBits'(1)) begin
              state <= S_JUDGE;
            end else begin
              k <= k + CntBits'(1);
            end
          end
        end
        S_JUDGE: begin
          res.is_stationary <= eval_on && (lhs >= rhs);
          res.sample_count  <= CountBits'(held);
          res.inlier_count  <= CountBits'(inliers);
          res_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_held_max, clk, rst, 1'b1, held <= MaxCnt)
  `ASSERT_IMPLIES(a_take_idle, clk, rst, item_take, state == S_IDLE)
  `ASSERT_IMPLIES(a_inl_le_held, clk, rst, state == S_JUDGE, inliers <= held)
  `ASSERT_NEXT(a_judge_out, clk, rst, state == S_JUDGE, res_valid)
endmodule

// File: rtl/wsd_front.sv
// Front end: configuration registers and input acceptance into the queue.
module wsd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic [15:0]       window_ms,
  output logic [14:0]       inlier_radius,
  output logic [8:0]        inlier_fraction_q8,
  input  logic              in_valid,
  input  wsd_pkg::in_item_t in_item,
  output logic              push_valid,
  output wsd_pkg::in_item_t push_item
);
  import wsd_pkg::*;
  assign push_valid = in_valid;
  // Missing positions carry no coordinates; zero them for cleaner storage.
  always_comb begin
    push_item = in_item;
    if (!in_item.pos_valid) begin
      push_item.pos_x = '0;
      push_item.pos_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms          <= 16'd1000;
      inlier_radius      <= 15'd50;
      inlier_fraction_q8 <= 9'd230;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWindow:   window_ms <= cfg_data;
        RegRadius:   inlier_radius <= cfg_data[14:0];
        RegFraction: inlier_fraction_q8 <= cfg_data[8:0];
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/windowed_stillness_detector.sv
// Top level of the windowed stillness detector.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall, payload in_item
//  out     | output    | out_valid / out_stall, payload out_item
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// An evaluated item is handled serially through the single read port: each trimmed sample
// is fetched and compared, then the sums read every held sample and the inlier test reads
// each again. A short run skips the sums and the inlier test; a missing one skips all.
// Reset is synchronous and clears control state and registers to their defaults.
// A two-entry queue lets inputs transfer while the engine works or the output stalls.
module windowed_stillness_detector #(
  parameter int MAX_SAMPLES = wsd_pkg::MaxSamplesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::out_item_t out_item
);
  import wsd_pkg::*;
  logic [15:0] window_ms;
  logic [14:0] inlier_radius;
  logic [8:0]  inlier_fraction_q8;
  logic        push_valid;
  in_item_t    push_item;
  logic        q_valid;
  logic        q_take;
  in_item_t    q_item;

  // The front end holds the configuration and hands items to the queue.
  wsd_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .window_ms, .inlier_radius, .inlier_fraction_q8,
    .in_valid, .in_item, .push_valid, .push_item
  );

  // The queue decouples input transfers from the evaluation engine.
  wsd_queue u_queue (
    .clk, .rst, .wr_valid(push_valid), .wr_stall(in_stall), .wr_data(push_item),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_item)
  );

  // The engine owns the sample ring and produces one result per item.
  wsd_engine #(.MAX_SAMPLES(MAX_SAMPLES)) u_engine (
    .clk, .rst, .item_valid(q_valid), .item_take(q_take), .item(q_item),
    .window_ms, .inlier_radius, .inlier_fraction_q8,
    .res_valid(out_valid), .res_stall(out_stall), .res(out_item)
  );
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the windowed stillness detector.
import wsd_pkg::*;

// Scoreboard: it keeps its own copy of the window state and the three registers.
// Each accepted input updates that copy and queues the verdict that the block must
// return. Each result that the block hands over is checked against the oldest one.
class stillness_scoreboard;
  localparam int Depth = 64;

  logic [15:0] win_len;
  logic [14:0] radius;
  logic [8:0]  frac_q8;

  logic [31:0]        stamp_mem [Depth];
  logic signed [15:0] x_mem [Depth];
  logic signed [15:0] y_mem [Depth];
  logic [5:0]         head;
  int                 held;
  logic [31:0]        run_start;

  out_item_t verdicts[$];
  int mismatches;
  int results_seen;
  int still_seen;
  int full_seen;

  function new();
    win_len = 16'd1000;
    radius = 15'd50;
    frac_q8 = 9'd230;
    head = '0;
    held = 0;
    run_start = '0;
    mismatches = 0;
    results_seen = 0;
    still_seen = 0;
    full_seen = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      RegWindow: win_len = val;
      RegRadius: radius = val[14:0];
      RegFraction: frac_q8 = val[8:0];
      default: ;
    endcase
  endfunction

  // Applies one accepted observation and queues the verdict it should produce.
  function void note_input(in_item_t it);
    out_item_t v;
    logic [31:0] now;
    logic [5:0] slot;
    longint n, sx, sy, ex, ey, lim;
    int inl;
    v = '0;
    now = it.timestamp_ms;
    if (!it.pos_valid) begin
      held = 0;
      head = '0;
      verdicts.push_back(v);
      return;
    end
    if (held == 0) run_start = now;
    if (held >= Depth) begin
      head = head + 6'd1;
      held = Depth - 1;
    end
    slot = head + 6'(held);
    stamp_mem[slot] = now;
    x_mem[slot] = it.pos_x;
    y_mem[slot] = it.pos_y;
    held++;
    if (held == Depth) full_seen++;
    // Drop samples that have aged out; ages wrap modulo 2^32.
    while (held > 0 && (now - stamp_mem[head]) > {16'd0, win_len}) begin
      head = head + 6'd1;
      held--;
    end
    inl = 0;
    if (held > 0 && (now - run_start) >= {16'd0, win_len}) begin
      n = held;
      sx = 0;
      sy = 0;
      lim = n * longint'(radius);
      for (int k = 0; k < held; k++) begin
        sx += longint'(x_mem[6'(head + 6'(k))]);
        sy += longint'(y_mem[6'(head + 6'(k))]);
      end
      // The centroid test is scaled by n so that it stays exact.
      for (int k = 0; k < held; k++) begin
        ex = n * longint'(x_mem[6'(head + 6'(k))]) - sx;
        ey = n * longint'(y_mem[6'(head + 6'(k))]) - sy;
        if (ex * ex + ey * ey <= lim * lim) inl++;
      end
      if (longint'(inl) * 256 >= longint'(frac_q8) * n) v.is_stationary = 1'b1;
    end
    v.sample_count = 7'(held);
    v.inlier_count = 7'(inl);
    verdicts.push_back(v);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with nothing expected: still=%0d count=%0d inliers=%0d",
                 got.is_stationary, got.sample_count, got.inlier_count);
      return;
    end
    want = verdicts[0];
    verdicts.delete(0);
    if (want.is_stationary) still_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: result %0d: expected still=%0d count=%0d inliers=%0d,",
                  " got still=%0d count=%0d inliers=%0d"},
                 results_seen, want.is_stationary, want.sample_count, want.inlier_count,
                 got.is_stationary, got.sample_count, got.inlier_count);
    end
  endfunction
endclass

module testbench;
  localparam longint CycleLimit = 3000000;
  localparam int ItemsPerPhase = 150;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  stillness_scoreboard board;
  longint cycles;
  int items_sent;
  int burst_left;
  int hold_left;
  bit long_hold_req;
  int cfg_writes;

  // Stimulus state for the random sequences: a running clock and a wandering center.
  logic [31:0] clock_ms;
  int center_x, center_y;

  windowed_stillness_detector dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Every result transfer is checked at the edge where it happens.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_item);
  end

  // The receiver switches in turn between stall patterns: free flowing, light
  // stalls and heavy stalls. A long hold-off can be requested, and then it stalls
  // without a break so that the block's input queue fills up.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 3000;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ((cycles / 400) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 25);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Offers one item and returns at the falling edge after its transfer. The sender
  // runs in bursts; between bursts valid usually drops for a random gap.
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 300)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.verdicts.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] clamp_coord(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic in_item_t make_item(logic v, logic [31:0] ts, int x, int y);
    in_item_t it;
    it.pos_valid = v;
    it.timestamp_ms = ts;
    it.pos_x = clamp_coord(x);
    it.pos_y = clamp_coord(y);
    return it;
  endfunction

  // Mostly a well-formed track: time moves forward by a small step and the
  // position jitters around a center. Now and then the position goes missing,
  // the clock jumps or steps back, an outlier appears, or the center moves.
  function automatic in_item_t track_item(int max_step, int jitter);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return make_item(1'b0, $urandom, $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768);
    if (r < 5) clock_ms = $urandom;
    else if (r < 7) clock_ms = clock_ms - $urandom_range(1, 5000);
    else clock_ms = clock_ms + $urandom_range(0, max_step);
    if ($urandom_range(0, 99) == 0) begin
      center_x = $urandom_range(0, 65535) - 32768;
      center_y = $urandom_range(0, 65535) - 32768;
    end
    if ($urandom_range(0, 99) < 6)
      return make_item(1'b1, clock_ms, $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768);
    return make_item(1'b1, clock_ms, center_x + $urandom_range(0, 2 * jitter) - jitter,
                     center_y + $urandom_range(0, 2 * jitter) - jitter);
  endfunction

  // When hold_first is set, the receiver holds off right after the register writes
  // while this phase keeps offering items.
  task automatic random_phase(logic [15:0] win, logic [14:0] rad, logic [8:0] frac,
                              int max_step, int jitter, bit hold_first);
    drain();
    write_reg(RegWindow, win);
    write_reg(RegRadius, {1'b0, rad});
    write_reg(RegFraction, {7'd0, frac});
    if (hold_first) long_hold_req = 1'b1;
    for (int i = 0; i < ItemsPerPhase; i++) begin
      if (i == 75 && $urandom_range(0, 1) == 0) drain();
      send_item(track_item(max_step, jitter));
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegWindow;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cycles = 0;
    items_sent = 0;
    burst_left = 0;
    hold_left = 0;
    long_hold_req = 1'b0;
    cfg_writes = 0;
    clock_ms = 32'd0;
    center_x = 0;
    center_y = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset settings: a missing position at the extremes,
    // samples at opposite corners, a run that just reaches the window, a sample
    // that just ages out, a clock that steps back and then wraps past zero.
    send_item(make_item(1'b0, 32'hFFFF_FFFF, -32768, 32767));
    send_item(make_item(1'b1, 32'd0, 32767, -32768));
    send_item(make_item(1'b1, 32'd500, -32768, 32767));
    send_item(make_item(1'b1, 32'd1000, 0, 0));
    send_item(make_item(1'b1, 32'd1001, 0, 0));
    send_item(make_item(1'b1, 32'd1500, 10, 10));
    send_item(make_item(1'b1, 32'd2001, 12, 9));
    send_item(make_item(1'b1, 32'hFFFF_FFF0, 1, -1));
    send_item(make_item(1'b1, 32'h0000_0010, 3, 2));
    send_item(make_item(1'b1, 32'h0000_03F8, -32768, -32768));
    send_item(make_item(1'b0, 32'h5555_AAAA, 32767, 32767));
    send_item(make_item(1'b1, 32'hAAAA_5555, 100, 100));
    send_item(make_item(1'b1, 32'hAAAA_5555, 100, 100));
    send_item(make_item(1'b1, 32'hAAAA_5940, 140, 100));
    send_item(make_item(1'b1, 32'hAAAA_5941, -32768, 32767));

    // Zero window: only samples with the current timestamp stay.
    drain();
    write_reg(RegWindow, 16'd0);
    write_reg(RegRadius, 16'd0);
    write_reg(RegFraction, 16'd0);
    send_item(make_item(1'b1, 32'd7, 5, 5));
    send_item(make_item(1'b1, 32'd7, 5, 5));
    send_item(make_item(1'b1, 32'd7, 6, 5));
    send_item(make_item(1'b1, 32'd8, 6, 5));

    // Random phases over a spread of settings, the extremes among them. The
    // second starts with a long receiver hold-off while the sender keeps going.
    random_phase(16'd100, 15'd20, 9'd230, 15, 10, 1'b0);
    random_phase(16'd1000, 15'd50, 9'd128, 8, 40, 1'b1);
    random_phase(16'd0, 15'd0, 9'd0, 2, 1, 1'b0);
    random_phase(16'd65535, 15'd32767, 9'd256, 2000, 3000, 1'b0);
    random_phase(16'd300, 15'd5, 9'd511, 20, 4, 1'b0);
    random_phase(16'd50, 15'd200, 9'd1, 10, 300, 1'b0);

    drain();
    $display("Covered %0d observations across %0d register writes; %0d stationary verdicts,",
             items_sent, cfg_writes, board.still_seen);
    $display("ring filled to capacity %0d times, %0d results checked, %0d mismatches.",
             board.full_seen, board.results_seen, board.mismatches);
    if (board.mismatches == 0 && board.verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/wsd_pkg.sv
rtl/wsd_queue.sv
rtl/wsd_engine.sv
rtl/wsd_front.sv
rtl/windowed_stillness_detector.sv
test/testbench.sv
